### rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
// used by dq_cell, dq_chain and double_ended_queue; depends on nothing
package dq_pkg;

	localparam int DEPTH  = 256;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic signed [WORD_W-1:0] EMPTY_MARK = 32'sd123456;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// request for a whole chain
	typedef struct packed {
		logic shr;
		logic shl;
		logic load;
	} chain_ctrl_t;

	// request for one cell
	typedef struct packed {
		logic shr;
		logic shl;
		logic load;
	} cell_ctrl_t;

endpackage

### rtl/dq_cell.sv
// one storage cell of a shift chain: holds one word
// shifts from either neighbor or loads the broadcast word; depends on dq_pkg
module dq_cell (
	input  logic               clk,
	input  dq_pkg::cell_ctrl_t ctrl,
	input  dq_pkg::word_t      from_left,
	input  dq_pkg::word_t      from_right,
	input  dq_pkg::word_t      bcast,
	output dq_pkg::word_t      data
);
	import dq_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= bcast;
		end else if (ctrl.shr) begin
			data_q <= from_left;
		end else if (ctrl.shl) begin
			data_q <= from_right;
		end
	end

	assign data = data_q;

endmodule

### rtl/dq_chain.sv
// row of DEPTH cells kept packed against cell 0
// insert at cell 0 by shifting right, remove by shifting left, append at the count; uses dq_cell
module dq_chain (
	input  logic                clk,
	input  dq_pkg::chain_ctrl_t ctrl,
	input  dq_pkg::count_t      count,
	input  dq_pkg::word_t       value,
	output dq_pkg::word_t       tap0,
	output dq_pkg::word_t       tap1
);
	import dq_pkg::*;

	word_t cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t cc;
		word_t      left_w;
		word_t      right_w;

		assign cc.shr  = ctrl.shr;
		assign cc.shl  = ctrl.shl;
		assign cc.load = ctrl.load && (count == CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = EMPTY_MARK;
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.ctrl       (cc),
			.from_left  (left_w),
			.from_right (right_w),
			.bcast      (value),
			.data       (cell_data[i])
		);
	end

	assign tap0 = cell_data[0];
	assign tap1 = cell_data[1];

endmodule

### rtl/double_ended_queue.sv
// Bounded double-ended queue of DEPTH signed 32-bit words. One request is taken
// every clock cycle while in_stall is low; its result (front and back words,
// count, empty, full and rejected flags) appears registered in the cycle after
// acceptance and is held while out_stall is high, with in_stall raised only when
// that held result blocks the next one. The words live in two mirrored chains of
// DEPTH cells, one packed from the front and one from the back, so both ends are
// read at fixed cells and every request is finished in the same cycle it is taken.
// A push on a full queue or a pop on an empty one changes nothing and is
// flagged; an empty queue reports 123456 at both ends. No clearing pass is
// needed after reset.
module double_ended_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic signed [31:0]   value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   front_value,
	output logic signed [31:0]   back_value,
	output logic [8:0]           entry_total,
	output logic                 is_empty,
	output logic                 is_full,
	output logic                 rejected
);
	import dq_pkg::*;

	op_t         op_w;
	logic        acc;
	logic        is_push;
	logic        full_w;
	logic        empty_w;
	logic        many_w;
	logic        rej_w;
	logic        do_w;
	count_t      count_q;
	count_t      count_d;
	chain_ctrl_t fctrl;
	chain_ctrl_t bctrl;
	word_t       f0;
	word_t       f1;
	word_t       r0;
	word_t       r1;
	word_t       front_now;
	word_t       back_now;
	word_t       front_d;
	word_t       back_d;

	logic        out_valid_q;
	word_t       front_q;
	word_t       back_q;
	count_t      total_q;
	logic        empty_q;
	logic        full_q;
	logic        rej_q;

	assign op_w     = op_t'(op);
	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	assign full_w  = (count_q == CNT_W'(DEPTH));
	assign empty_w = (count_q == '0);
	assign many_w  = (count_q > CNT_W'(1));
	assign is_push = (op_w == OP_PUSH_FRONT) || (op_w == OP_PUSH_BACK);
	assign rej_w   = is_push ? full_w : empty_w;
	assign do_w    = acc && !rej_w;

	assign fctrl.shr  = do_w && (op_w == OP_PUSH_FRONT);
	assign fctrl.load = do_w && (op_w == OP_PUSH_BACK);
	assign fctrl.shl  = do_w && (op_w == OP_POP_FRONT);
	assign bctrl.shr  = do_w && (op_w == OP_PUSH_BACK);
	assign bctrl.load = do_w && (op_w == OP_PUSH_FRONT);
	assign bctrl.shl  = do_w && (op_w == OP_POP_BACK);

	dq_chain u_front (
		.clk   (clk),
		.ctrl  (fctrl),
		.count (count_q),
		.value (value),
		.tap0  (f0),
		.tap1  (f1)
	);

	dq_chain u_back (
		.clk   (clk),
		.ctrl  (bctrl),
		.count (count_q),
		.value (value),
		.tap0  (r0),
		.tap1  (r1)
	);

	assign front_now = empty_w ? EMPTY_MARK : f0;
	assign back_now  = empty_w ? EMPTY_MARK : r0;

	always_comb begin
		count_d = count_q;
		front_d = front_now;
		back_d  = back_now;
		case (op_w)
			OP_PUSH_FRONT: begin
				if (!full_w) begin
					count_d = count_q + CNT_W'(1);
					front_d = value;
					back_d  = empty_w ? value : r0;
				end
			end
			OP_PUSH_BACK: begin
				if (!full_w) begin
					count_d = count_q + CNT_W'(1);
					front_d = empty_w ? value : f0;
					back_d  = value;
				end
			end
			OP_POP_FRONT: begin
				if (!empty_w) begin
					count_d = count_q - CNT_W'(1);
				end
				front_d = many_w ? f1 : EMPTY_MARK;
				back_d  = many_w ? r0 : EMPTY_MARK;
			end
			OP_POP_BACK: begin
				if (!empty_w) begin
					count_d = count_q - CNT_W'(1);
				end
				front_d = many_w ? f0 : EMPTY_MARK;
				back_d  = many_w ? r1 : EMPTY_MARK;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			front_q <= front_d;
			back_q  <= back_d;
			total_q <= count_d;
			empty_q <= (count_d == '0);
			full_q  <= (count_d == CNT_W'(DEPTH));
			rej_q   <= rej_w;
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign entry_total = total_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign rejected    = rej_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_push && !rej_w) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted push did not grow the count");

	a_empty_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |->
		(front_q == EMPTY_MARK && back_q == EMPTY_MARK && total_q == '0))
		else $error("empty result without sentinel");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rej_w) |=> (count_q == $past(count_q)))
		else $error("rejected request changed the count");
`endif

endmodule
